>>> rtl/ppi_pkg.sv
`timescale 1ns / 1ps
package ppi_pkg;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_COS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_SIN      = 3'd5;

  localparam logic [6:0]  RST_VERTEX_COUNT = 7'd3;
  localparam logic [31:0] RST_SCALE        = 32'd65536;
  localparam logic [15:0] RST_ROT_COS      = 16'd16384;

  localparam logic signed [48:0] SAT_HI = 49'sd2147483647;
  localparam logic signed [48:0] SAT_LO = -49'sd2147483648;

  typedef struct packed {
    logic        is_query;
    logic        wr_en;
    logic [5:0]  idx;
    logic [31:0] x;
    logic [31:0] y;
  } item_t;

  typedef struct packed {
    logic [6:0]  vertex_count;
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] scale;
    logic [15:0] rot_cos;
    logic [15:0] rot_sin;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) r = 32'sh7fffffff;
    else if (v < SAT_LO) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

>>> rtl/ppi_if.sv
`timescale 1ns / 1ps
interface ppi_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [5:0]  vertex_index;
  logic [31:0] coord_x;
  logic [31:0] coord_y;
  modport source (output valid, cmd, vertex_index, coord_x, coord_y, input ready);
  modport sink (input valid, cmd, vertex_index, coord_x, coord_y, output ready);
endinterface

interface ppi_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

>>> rtl/ppi_front.sv
`timescale 1ns / 1ps
module ppi_front #(
  parameter int MaxVertices = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  ppi_in_if.sink         in_if,
  output ppi_pkg::item_t item_o,
  output logic           item_valid_o,
  input  logic           item_ready_i
);

  localparam int CmpW = 14;

  ppi_pkg::item_t fifo_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q;
  logic           push, pop;
  ppi_pkg::item_t item_in;

  // classify: writes beyond the store are flagged here, the back end skips them
  always_comb begin
    item_in.is_query = (in_if.cmd == ppi_pkg::CMD_QUERY);
    item_in.wr_en    = (in_if.cmd == ppi_pkg::CMD_WRITE) &&
                       (CmpW'(in_if.vertex_index) < CmpW'(MaxVertices));
    item_in.idx      = in_if.vertex_index;
    item_in.x        = in_if.coord_x;
    item_in.y        = in_if.coord_y;
  end

  assign in_if.ready  = (cnt_q != 2'd2);
  assign push         = in_if.valid && in_if.ready;
  assign item_valid_o = (cnt_q != 2'd0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = fifo_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wptr_q] <= item_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> rtl/ppi_back.sv
`timescale 1ns / 1ps
module ppi_back #(
  parameter int MaxVertices = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ppi_pkg::cfg_t  cfg_i,
  input  ppi_pkg::item_t item_i,
  input  logic           item_valid_i,
  output logic           item_ready_o,
  ppi_out_if.source      out_if
);

  localparam int AW  = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int CW  = $clog2(MaxVertices + 1);
  localparam int NW  = (CW > 7) ? CW : 7;
  localparam int IXW = AW + 6;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0] state_q;
  logic [31:0] mem_x [MaxVertices];
  logic [31:0] mem_y [MaxVertices];

  logic [NW-1:0] n_eff, n_q, iss_q, cnt_ext, raddr_w;
  logic [IXW-1:0] widx;
  logic          pop, do_wr, do_rd;
  logic [AW-1:0] raddr;

  logic signed [31:0] qx_q, qy_q;
  logic inside_q, res_q, out_valid_q, out_res_q;

  // pipeline valid and walk flags
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic f1_q, f2_q, f3_q, f4_q, f5_q;
  logic l1_q, l2_q, l3_q, l4_q, l5_q, l6_q;

  logic signed [31:0] rdx_q, rdy_q;
  logic signed [47:0] pxc_q, pys_q, pyc_q, pxs_q;
  logic signed [31:0] rx_q, ry_q;
  logic signed [63:0] mx_q, my_q;
  logic signed [31:0] wx_q, wy_q, px_q, py_q;
  logic               cond_q, dpos_q;
  logic signed [65:0] lp_q, rp_q;

  logic signed [15:0] cosv, sinv;
  logic signed [31:0] scv;
  logic signed [48:0] sx, sy, tx, ty;
  logic signed [32:0] dy, ddx, dxe, dye;
  logic               cond, tog;

  assign cosv = $signed(cfg_i.rot_cos);
  assign sinv = $signed(cfg_i.rot_sin);
  assign scv  = $signed(cfg_i.scale);

  // vertex count clipped to the store depth
  assign cnt_ext = NW'(cfg_i.vertex_count);
  assign n_eff   = (cnt_ext > NW'(MaxVertices)) ? NW'(MaxVertices) : cnt_ext;

  assign item_ready_o = (state_q == ST_IDLE);
  assign pop          = item_valid_i && item_ready_o;
  assign do_wr        = pop && !item_i.is_query && item_i.wr_en;
  assign widx         = IXW'(item_i.idx);
  assign do_rd        = (state_q == ST_WALK) && (iss_q <= n_q);
  // first read is the closing vertex, then vertex 0 upward
  assign raddr_w      = (iss_q == '0) ? (n_q - NW'(1)) : (iss_q - NW'(1));
  assign raddr        = raddr_w[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_x[widx[AW-1:0]] <= item_i.x;
      mem_y[widx[AW-1:0]] <= item_i.y;
    end
    if (do_rd) begin
      rdx_q <= mem_x[raddr];
      rdy_q <= mem_y[raddr];
    end
  end

  // rotate, scale and offset
  always_comb begin
    sx = (49'(pxc_q) - 49'(pys_q)) >>> 14;
    sy = (49'(pyc_q) + 49'(pxs_q)) >>> 14;
    tx = 49'($signed(mx_q[63:16])) + 49'($signed(cfg_i.center_x));
    ty = 49'($signed(my_q[63:16])) + 49'($signed(cfg_i.center_y));
  end

  // edge test against the previous world vertex
  always_comb begin
    cond = ((wy_q <= qy_q) && (qy_q < py_q)) || ((py_q <= qy_q) && (qy_q < wy_q));
    dy   = 33'(py_q) - 33'(wy_q);
    ddx  = 33'(qx_q) - 33'(wx_q);
    dxe  = 33'(px_q) - 33'(wx_q);
    dye  = 33'(qy_q) - 33'(wy_q);
    tog  = v6_q && cond_q && (dpos_q ? (lp_q < rp_q) : (lp_q > rp_q));
  end

  always_ff @(posedge clk_i) begin
    pxc_q <= rdx_q * cosv;
    pys_q <= rdy_q * sinv;
    pyc_q <= rdy_q * cosv;
    pxs_q <= rdx_q * sinv;
    rx_q  <= ppi_pkg::sat32(sx);
    ry_q  <= ppi_pkg::sat32(sy);
    mx_q  <= rx_q * scv;
    my_q  <= ry_q * scv;
    wx_q  <= ppi_pkg::sat32(tx);
    wy_q  <= ppi_pkg::sat32(ty);
    if (v5_q) begin
      px_q <= wx_q;
      py_q <= wy_q;
    end
    cond_q <= cond;
    dpos_q <= (py_q > wy_q);
    lp_q   <= ddx * dy;
    rp_q   <= dxe * dye;
    if (pop) begin
      qx_q <= $signed(item_i.x);
      qy_q <= $signed(item_i.y);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q <= '0;
      iss_q <= '0;
      inside_q <= 1'b0;
      res_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_res_q <= 1'b0;
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q} <= '0;
      {f1_q, f2_q, f3_q, f4_q, f5_q} <= '0;
      {l1_q, l2_q, l3_q, l4_q, l5_q, l6_q} <= '0;
    end else begin
      v1_q <= do_rd;
      f1_q <= (iss_q == '0);
      l1_q <= (iss_q == n_q);
      {v2_q, v3_q, v4_q, v5_q} <= {v1_q, v2_q, v3_q, v4_q};
      {f2_q, f3_q, f4_q, f5_q} <= {f1_q, f2_q, f3_q, f4_q};
      {l2_q, l3_q, l4_q, l5_q} <= {l1_q, l2_q, l3_q, l4_q};
      v6_q <= v5_q && !f5_q;
      l6_q <= l5_q;
      if ((state_q == ST_HOLD) && (!out_valid_q || out_if.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop && item_i.is_query) begin
            if ($signed(cfg_i.scale) <= 32'sd0 || n_eff == '0) begin
              res_q   <= 1'b0;
              state_q <= ST_HOLD;
            end else begin
              n_q      <= n_eff;
              iss_q    <= '0;
              inside_q <= 1'b0;
              state_q  <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (do_rd) iss_q <= iss_q + NW'(1);
          inside_q <= inside_q ^ tog;
          if (v6_q && l6_q) begin
            res_q   <= inside_q ^ tog;
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (!out_valid_q || out_if.ready) begin
            out_res_q   <= res_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.inside_res = out_res_q;

endmodule

>>> rtl/polygon_point_inclusion.sv
`timescale 1ns / 1ps
// polygon_point_inclusion: crossing-number point-in-polygon test
// input channel in_if: cmd 0 stores vertex (coord_x, coord_y) at vertex_index,
//   cmd 1 queries point (coord_x, coord_y); a transaction moves on valid && ready
// output channel out_if: one transaction per query carrying inside_res,
//   vertex writes give no output
// config port: cfg_we_i writes cfg_data_i into register cfg_index_i
//   (0 vertex_count, 1 center_x, 2 center_y, 3 scale, 4 rot_cos, 5 rot_sin)
// timing: a query reads n+1 vertices, one per cycle from the vertex memory
//   read port, and passes them through the pipeline (rotate, scale, edge
//   products, compare)
// an empty polygon (scale <= 0 or count 0) skips the walk and answers inside_res 0
// a two-entry queue sits between input classification and the walk engine,
//   so up to two items are taken while the engine or the output is busy
// if the receiver stalls, the result holds in the output register and the
//   engine waits for the next result until it is taken
// reset: registers return to count 3, center 0, scale 1.0, no rotation;
//   vertex memory contents are undefined until written
module polygon_point_inclusion #(
  parameter int MAX_VERTICES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ppi_in_if.sink      in_if,
  ppi_out_if.source   out_if,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  ppi_pkg::cfg_t  cfg_q;
  ppi_pkg::item_t item;
  logic           item_valid, item_ready;

  // configuration registers, ignored indexes fall through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vertex_count <= ppi_pkg::RST_VERTEX_COUNT;
      cfg_q.center_x     <= '0;
      cfg_q.center_y     <= '0;
      cfg_q.scale        <= ppi_pkg::RST_SCALE;
      cfg_q.rot_cos      <= ppi_pkg::RST_ROT_COS;
      cfg_q.rot_sin      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ppi_pkg::CFG_VERTEX_COUNT: cfg_q.vertex_count <= cfg_data_i[6:0];
        ppi_pkg::CFG_CENTER_X:     cfg_q.center_x     <= cfg_data_i;
        ppi_pkg::CFG_CENTER_Y:     cfg_q.center_y     <= cfg_data_i;
        ppi_pkg::CFG_SCALE:        cfg_q.scale        <= cfg_data_i;
        ppi_pkg::CFG_ROT_COS:      cfg_q.rot_cos      <= cfg_data_i[15:0];
        ppi_pkg::CFG_ROT_SIN:      cfg_q.rot_sin      <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // front end: classify and queue
  ppi_front #(.MaxVertices(MAX_VERTICES)) u_front (
    .clk_i, .rst_ni,
    .in_if        (in_if),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready)
  );

  // back end: vertex store, transform pipeline, crossing count
  ppi_back #(.MaxVertices(MAX_VERTICES)) u_back (
    .clk_i, .rst_ni,
    .cfg_i        (cfg_q),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .out_if       (out_if)
  );

endmodule

>>> bench/tb_polygon_point_inclusion.sv
`timescale 1ns / 1ps
module tb_polygon_point_inclusion;

  localparam int NUM_SLOTS = 64;
  localparam int PHASES    = 14;
  localparam int PHASE_LEN = 95;
  // indexes above the defined register map, the block must ignore them
  localparam logic [ppi_pkg::CFG_IDX_W-1:0] CFG_SPARE    = 3'd6;
  localparam logic [ppi_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  // cycles to let a trailing vertex write drain before a register write
  localparam int DRAIN_CYCLES = 90;

  typedef struct {
    logic               cmd;
    logic [5:0]         idx;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } ppi_txn_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  ppi_in_if  in_if ();
  ppi_out_if out_if ();

  polygon_point_inclusion u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if.sink),
    .out_if      (out_if.source),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // pending transactions waiting for the driver, and expected inside flags
  ppi_txn_t pend_q[$];
  bit       inside_q[$];
  int       err_cnt = 0;

  // predictor copy of the vertex store and the registers
  logic signed [31:0] vx_mem [NUM_SLOTS];
  logic signed [31:0] vy_mem [NUM_SLOTS];
  logic [6:0]         p_count = ppi_pkg::RST_VERTEX_COUNT;
  logic signed [31:0] p_cx = '0;
  logic signed [31:0] p_cy = '0;
  logic signed [31:0] p_scale = ppi_pkg::RST_SCALE;
  logic signed [15:0] p_cos = ppi_pkg::RST_ROT_COS;
  logic signed [15:0] p_sin = '0;

  // traffic shaping controls, written by the stimulus and the ready process
  bit steady = 1'b0;
  int hold_trig = 0;
  int hold_seen = 0;
  int hold_cnt = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // local vertex -> rotated, scaled, offset world point
  function automatic void vertex_to_world(input int i, output longint wx, output longint wy);
    longint lx, ly, c, s, sc, rx, ry;
    lx = vx_mem[i];
    ly = vy_mem[i];
    c = p_cos;
    s = p_sin;
    sc = p_scale;
    rx = clamp32((lx * c - ly * s) >>> 14);
    ry = clamp32((ly * c + lx * s) >>> 14);
    wx = clamp32(((rx * sc) >>> 16) + longint'(p_cx));
    wy = clamp32(((ry * sc) >>> 16) + longint'(p_cy));
  endfunction

  function automatic int slots_in_use();
    if (p_scale <= 0 || p_count == 0) return 0;
    return (p_count > NUM_SLOTS) ? NUM_SLOTS : int'(p_count);
  endfunction

  // crossing-number test over the closed polygon, exact cross-multiplied compare
  function automatic bit point_inside(input longint x, input longint y);
    int n;
    bit odd;
    longint xp, yp, xpp, ypp, dy;
    logic signed [67:0] a, b, lhs, rhs;
    n = slots_in_use();
    odd = 1'b0;
    if (n == 0) return 1'b0;
    vertex_to_world(n - 1, xpp, ypp);
    for (int i = 0; i < n; i++) begin
      vertex_to_world(i, xp, yp);
      if ((yp <= y && y < ypp) || (ypp <= y && y < yp)) begin
        dy = ypp - yp;
        a = x - xp;
        b = dy;
        lhs = a * b;
        a = xpp - xp;
        b = y - yp;
        rhs = a * b;
        if ((dy > 0 && lhs < rhs) || (dy < 0 && lhs > rhs)) odd = ~odd;
      end
      xpp = xp;
      ypp = yp;
    end
    return odd;
  endfunction

  // input driver, also feeds the predictor on each accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid        <= 1'b0;
      in_if.cmd          <= ppi_pkg::CMD_WRITE;
      in_if.vertex_index <= '0;
      in_if.coord_x      <= '0;
      in_if.coord_y      <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        if (in_if.cmd == ppi_pkg::CMD_WRITE) begin
          vx_mem[in_if.vertex_index] = in_if.coord_x;
          vy_mem[in_if.vertex_index] = in_if.coord_y;
        end else begin
          inside_q.push_back(point_inside(longint'($signed(in_if.coord_x)),
                                          longint'($signed(in_if.coord_y))));
        end
      end
      if (!in_if.valid || in_if.ready) begin
        if (pend_q.size() > 0 && (steady || $urandom_range(0, 99) >= 10)) begin
          ppi_txn_t t;
          t = pend_q.pop_front();
          in_if.valid        <= 1'b1;
          in_if.cmd          <= t.cmd;
          in_if.vertex_index <= t.idx;
          in_if.coord_x      <= t.x;
          in_if.coord_y      <= t.y;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // output ready: random stalls, or a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_trig != hold_seen) begin
      hold_seen    <= hold_trig;
      hold_cnt     <= 400;
      out_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt     <= hold_cnt - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= steady || ($urandom_range(0, 99) >= 10);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (inside_q.size() == 0) begin
        $display("%0t: unexpected result inside_res=%0b", $time, out_if.inside_res);
        err_cnt++;
      end else begin
        bit exp_in;
        exp_in = inside_q.pop_front();
        if (out_if.inside_res !== exp_in) begin
          $display("%0t: inside_res mismatch expected %0b actual %0b",
                   $time, exp_in, out_if.inside_res);
          err_cnt++;
        end
      end
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      ppi_pkg::CFG_VERTEX_COUNT: p_count = data[6:0];
      ppi_pkg::CFG_CENTER_X:     p_cx = data;
      ppi_pkg::CFG_CENTER_Y:     p_cy = data;
      ppi_pkg::CFG_SCALE:        p_scale = data;
      ppi_pkg::CFG_ROT_COS:      p_cos = data[15:0];
      ppi_pkg::CFG_ROT_SIN:      p_sin = data[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] cnt, input logic [31:0] cx,
                            input logic [31:0] cy, input logic [31:0] sc,
                            input logic [15:0] c, input logic [15:0] s);
    reg_write(ppi_pkg::CFG_VERTEX_COUNT, cnt);
    reg_write(ppi_pkg::CFG_CENTER_X, cx);
    reg_write(ppi_pkg::CFG_CENTER_Y, cy);
    reg_write(ppi_pkg::CFG_SCALE, sc);
    reg_write(ppi_pkg::CFG_ROT_COS, {{16{c[15]}}, c});
    reg_write(ppi_pkg::CFG_ROT_SIN, {{16{s[15]}}, s});
  endtask

  task automatic push_txn(input logic cmd, input logic [5:0] idx,
                          input logic [31:0] x, input logic [31:0] y);
    ppi_txn_t t;
    t.cmd = cmd;
    t.idx = idx;
    t.x = x;
    t.y = y;
    pend_q.push_back(t);
  endtask

  // blocks until every queued transaction went in and every result came out
  task automatic wait_drained();
    while (pend_q.size() > 0 || in_if.valid || inside_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rnd_span(input int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic logic [15:0] rnd_rot();
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  // query near the transformed polygon, sometimes on a vertex height
  task automatic gen_query(input int n);
    longint reach, qx, qy, wx, wy;
    reach = (p_scale > 0) ? ((longint'(700000) * longint'(p_scale)) >>> 16) + 65536 : 1 << 20;
    if (reach > 64'sd2147483647) reach = 64'sd2147483647;
    qx = clamp32(longint'(p_cx) + $signed(longint'($urandom_range(0, 2000))) * reach / 1000 - reach);
    qy = clamp32(longint'(p_cy) + $signed(longint'($urandom_range(0, 2000))) * reach / 1000 - reach);
    if (n > 0 && $urandom_range(0, 3) == 0) begin
      vertex_to_world($urandom_range(0, n - 1), wx, wy);
      qy = wy;
      if ($urandom_range(0, 1)) qx = wx;
    end
    push_txn(ppi_pkg::CMD_QUERY, 6'($urandom), qx[31:0], qy[31:0]);
  endtask

  initial begin
    int n;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      steady = (ph == 8);
      case (ph)
        0: ;  // reset values: three vertices, unit scale, no rotation
        1: set_config(8, rnd_span(1 << 20), rnd_span(1 << 20), 32'h10000, 16'sd14189, 16'sd8192);
        2: set_config(64, 0, 0, 32'h8000, 16'sd0, 16'sd16384);
        3: set_config(1, 0, 0, 32'h10000, 16'sd16384, 16'sd0);
        4: set_config(0, 0, 0, 32'h10000, 16'sd16384, 16'sd0);
        5: set_config(6, 0, 0, 32'h0, 16'sd16384, 16'sd0);
        6: set_config(6, 0, 0, 32'h80000000, 16'sd16384, 16'sd0);
        7: set_config(127, 32'h7fffffff, 32'h80000000, 32'h7fffffff, -16'sd16384, -16'sd16384);
        9: begin
          set_config(5, rnd_span(1 << 18), rnd_span(1 << 18), 32'h18000, rnd_rot(), rnd_rot());
          reg_write(CFG_SPARE, 32'h1);
          reg_write(CFG_SPARE_HI, $urandom);
        end
        default: set_config($urandom_range(3, 16), rnd_span(1 << 22), rnd_span(1 << 22),
                            $urandom_range(16384, 262144), rnd_rot(), rnd_rot());
      endcase
      n = slots_in_use();

      // fresh polygon for every slot that a query will read, or more
      for (int i = 0; i < ((p_count > NUM_SLOTS) ? NUM_SLOTS : int'(p_count)); i++)
        push_txn(ppi_pkg::CMD_WRITE, 6'(i), rnd_span(524288), rnd_span(524288));
      if (ph == 0) begin
        // known triangle plus corner cases of the fields
        push_txn(ppi_pkg::CMD_WRITE, 0, 32'hfffb0000, 32'hfffb0000);
        push_txn(ppi_pkg::CMD_WRITE, 1, 32'h00050000, 32'hfffb0000);
        push_txn(ppi_pkg::CMD_WRITE, 2, 32'h00000000, 32'h00050000);
        push_txn(ppi_pkg::CMD_QUERY, 0, 32'h0, 32'h0);
        push_txn(ppi_pkg::CMD_QUERY, 6'h3f, 32'h00100000, 32'h0);
        push_txn(ppi_pkg::CMD_QUERY, 0, 32'hfffb0000, 32'hfffb0000);
        push_txn(ppi_pkg::CMD_QUERY, 0, 32'h0, 32'h00050000);
        push_txn(ppi_pkg::CMD_QUERY, 0, 32'h00010000, 32'hfffb0000);
        push_txn(ppi_pkg::CMD_QUERY, 0, 32'h7fffffff, 32'h7fffffff);
        push_txn(ppi_pkg::CMD_QUERY, 0, 32'h80000000, 32'h80000000);
        push_txn(ppi_pkg::CMD_QUERY, 0, 32'h80000000, 32'h0);
        push_txn(ppi_pkg::CMD_WRITE, 6'h3f, 32'h7fffffff, 32'h80000000);
        push_txn(ppi_pkg::CMD_WRITE, 6'h3e, 32'h80000000, 32'h7fffffff);
        push_txn(ppi_pkg::CMD_QUERY, 0, 32'hffff0000, 32'h0);
      end
      if (ph == 3) hold_trig++;
      if (ph == 7) begin
        push_txn(ppi_pkg::CMD_QUERY, 0, 32'h7ffffffe, 32'h80000001);
        push_txn(ppi_pkg::CMD_QUERY, 0, 32'h0, 32'h0);
      end

      for (int k = 0; k < PHASE_LEN; k++) begin
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) gen_query(n);
        else if (pick < 90)
          push_txn(ppi_pkg::CMD_WRITE, 6'($urandom_range(0, NUM_SLOTS - 1)),
                   rnd_span(524288), rnd_span(524288));
        else if (pick < 95)
          push_txn(ppi_pkg::CMD_WRITE, 6'($urandom_range(0, NUM_SLOTS - 1)),
                   $urandom, $urandom);
        else push_txn(ppi_pkg::CMD_QUERY, 6'($urandom), $urandom, $urandom);
      end
    end

    wait_drained();
    if (err_cnt == 0) begin
      $display("polygon_point_inclusion verification clean");
    end else begin
      $display("polygon_point_inclusion verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("polygon_point_inclusion verification failed");
    $finish;
  end

endmodule
